/* sv/rsi_pkg.sv */
// Shared types, constants and saturation helpers for the ray/sphere intersection unit.
// No dependencies; every other file except rsi_if imports this package.
package rsi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int NORM_W    = 18;

  localparam int MUL_LAT  = 2;
  localparam int SQRT_LAT = 50;
  localparam int DIV_LAT  = 34;

  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_MIN_DIST = 3'd4;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             v;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [31:0]      best;
  } rsi_ray_t;

  typedef struct packed {
    logic                   hit;
    logic [31:0]            hit_t;
    logic [2:0][31:0]       point;
    logic [2:0][NORM_W-1:0] normal;
    logic [2:0][NORM_W-1:0] facing;
  } rsi_res_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? Q_MIN : Q_MAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat49(input logic [48:0] v);
    logic [31:0] r;
    if (v[48:31] != {18{v[48]}}) r = v[48] ? Q_MIN : Q_MAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_root(input logic neg, input logic ovf,
                                           input logic [32:0] q);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > {1'b0, Q_MIN}) r = Q_MIN;
      else r = 32'(-q);
    end else begin
      if (ovf || q > {1'b0, Q_MAX}) r = Q_MAX;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/rsi_if.sv */
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on nothing.
interface rsi_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] ray_origin_x;
  logic [31:0] ray_origin_y;
  logic [31:0] ray_origin_z;
  logic [31:0] ray_dir_x;
  logic [31:0] ray_dir_y;
  logic [31:0] ray_dir_z;
  logic [31:0] best_t;

  modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, best_t, input ready);
  modport sink   (input valid, ray_origin_x, ray_origin_y, ray_origin_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, best_t, output ready);
endinterface

interface rsi_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] hit_t;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [17:0] normal_x;
  logic [17:0] normal_y;
  logic [17:0] normal_z;
  logic [17:0] facing_x;
  logic [17:0] facing_y;
  logic [17:0] facing_z;

  modport source (output valid, hit, hit_t, point_x, point_y, point_z, normal_x,
                  normal_y, normal_z, facing_x, facing_y, facing_z, input ready);
  modport sink   (input valid, hit, hit_t, point_x, point_y, point_z, normal_x,
                  normal_y, normal_z, facing_x, facing_y, facing_z, output ready);
endinterface

/* sv/rsi_mul.sv */
// Two-stage 50x50 unsigned multiplier built from four 25x25 partial products.
// Depends on rsi_pkg.
module rsi_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [49:0] a_i,
  input  logic [49:0] b_i,
  output logic [99:0] p_o
);
  import rsi_pkg::*;

  logic [49:0] hh_q, hl_q, lh_q, ll_q;
  logic [99:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= a_i[49:25] * b_i[49:25];
      hl_q <= a_i[49:25] * b_i[24:0];
      lh_q <= a_i[24:0] * b_i[49:25];
      ll_q <= a_i[24:0] * b_i[24:0];
      p_q  <= {hh_q, 50'd0} + {24'd0, 51'({1'b0, hl_q} + {1'b0, lh_q}), 25'd0}
              + {50'd0, ll_q};
    end
  end

  assign p_o = p_q;

endmodule

/* sv/rsi_sqrt.sv */
// Pipelined integer square root, one root bit per stage, 100-bit radicand.
// Depends on rsi_pkg.
module rsi_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [99:0] rad_i,
  output logic [49:0] root_o
);
  import rsi_pkg::*;

  logic [99:0] rad_q  [SQRT_LAT];
  logic [53:0] rem_q  [SQRT_LAT];
  logic [49:0] root_q [SQRT_LAT];
  logic [99:0] src_rad  [SQRT_LAT];
  logic [53:0] src_rem  [SQRT_LAT];
  logic [49:0] src_root [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    logic [53:0] rem_sh, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign src_rad[k]  = rad_i;
      assign src_rem[k]  = '0;
      assign src_root[k] = '0;
    end else begin : g_next
      assign src_rad[k]  = rad_q[k-1];
      assign src_rem[k]  = rem_q[k-1];
      assign src_root[k] = root_q[k-1];
    end

    always_comb begin
      rem_sh = {src_rem[k][51:0], src_rad[k][99:98]};
      trial  = {2'b00, src_root[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {src_rad[k][97:0], 2'b00};
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {src_root[k][48:0], ge};
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

/* sv/rsi_div.sv */
// Pipelined restoring divider: floor(m * 2^16 / den), one quotient bit per stage,
// with an overflow flag for quotients of 2^33 and more. Depends on rsi_pkg.
module rsi_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [50:0] m_i,
  input  logic [48:0] den_i,
  output logic        ovf_o,
  output logic [32:0] q_o
);
  import rsi_pkg::*;

  logic [66:0] rem_q [DIV_LAT];
  logic [48:0] den_q [DIV_LAT];
  logic [32:0] q_q   [DIV_LAT];
  logic        ovf_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {m_i, 16'd0};
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= {15'd0, m_i} >= {den_i, 17'd0};
    end
  end

  for (genvar k = 0; k < DIV_LAT - 1; k++) begin : g_st
    logic [81:0] trial, rem_x;
    logic        ge;

    always_comb begin
      trial = {33'd0, den_q[k]} << (DIV_LAT - 2 - k);
      rem_x = {15'd0, rem_q[k]};
      ge    = rem_x >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 67'(rem_x - trial) : rem_q[k];
        den_q[k+1] <= den_q[k];
        q_q[k+1]   <= {q_q[k][31:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_o   = q_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

/* sv/rsi_root.sv */
// Quadratic front end: coefficients, discriminant, root and nearest valid hit distance.
// Depends on rsi_pkg, rsi_mul, rsi_sqrt and rsi_div.
module rsi_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rsi_pkg::rsi_ray_t         ray_i,
  input  logic [2:0][31:0]          ctr_i,
  input  logic [30:0]               radius_i,
  input  logic [31:0]               min_dist_i,
  output rsi_pkg::rsi_ray_t         ray_o,
  output logic                      hit_o,
  output logic [31:0]               t_o
);
  import rsi_pkg::*;

  typedef struct packed {
    rsi_ray_t    ray;
    logic [50:0] hb;
    logic [49:0] a;
    logic        cle;
    logic        anz;
  } coef_t;

  typedef struct packed {
    rsi_ray_t    ray;
    logic [50:0] hb;
    logic [49:0] a;
    logic        pos;
  } quad_t;

  rsi_ray_t          ray1_q, ray2_q;
  logic [2:0][31:0]  o1_q;
  logic [2:0][63:0]  dd2_q, od2_q, oo2_q;
  logic [61:0]       rr2_q;
  coef_t             coef3_q, coef4_q, coef5_q;
  logic [50:0]       c3_q;
  logic [49:0]       hb_mag, c_mag;
  logic [99:0]       hb2, ac;
  quad_t             quad6_q;
  logic [99:0]       disc6_q;
  logic [99:0]       disc_d;
  logic              pos_d;
  quad_t             dl_s_q [SQRT_LAT];
  quad_t             dl_d_q [DIV_LAT];
  logic [49:0]       s;
  quad_t             qn_q;
  logic [50:0]       m0_q, m1_q;
  logic              neg0_q, neg1_q;
  logic [52:0]       n0, n1;
  logic              ovf0, ovf1;
  logic [32:0]       q0, q1;
  logic [31:0]       r0, r1;
  logic              ok0, ok1;
  rsi_ray_t          ray_q;
  logic              hit_q;
  logic [31:0]       t_q;
  logic [50:0]       a_sum, hb_sum, c_sum;

  always_comb begin
    a_sum  = '0;
    hb_sum = '0;
    c_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      a_sum  = a_sum + {3'd0, dd2_q[i][63:16]};
      hb_sum = hb_sum + {{3{od2_q[i][63]}}, od2_q[i][63:16]};
      c_sum  = c_sum + {{3{oo2_q[i][63]}}, oo2_q[i][63:16]};
    end
    c_sum = c_sum - {5'd0, rr2_q[61:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray1_q.v  <= 1'b0;
      ray2_q.v  <= 1'b0;
      coef3_q.ray.v <= 1'b0;
      coef4_q.ray.v <= 1'b0;
      coef5_q.ray.v <= 1'b0;
      quad6_q.ray.v <= 1'b0;
      qn_q.ray.v    <= 1'b0;
      ray_q.v       <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) dl_s_q[k].ray.v <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dl_d_q[k].ray.v <= 1'b0;
    end else if (en_i) begin
      ray1_q  <= ray_i;
      ray2_q  <= ray1_q;
      coef3_q <= '{ray: ray2_q, hb: hb_sum, a: a_sum[49:0],
                   cle: c_sum[50] || (c_sum == '0), anz: a_sum != '0};
      coef4_q <= coef3_q;
      coef5_q <= coef4_q;
      quad6_q <= '{ray: coef5_q.ray, hb: coef5_q.hb, a: coef5_q.a, pos: pos_d};
      dl_s_q[0] <= quad6_q;
      for (int k = 1; k < SQRT_LAT; k++) dl_s_q[k] <= dl_s_q[k-1];
      qn_q <= dl_s_q[SQRT_LAT-1];
      dl_d_q[0] <= qn_q;
      for (int k = 1; k < DIV_LAT; k++) dl_d_q[k] <= dl_d_q[k-1];
      ray_q <= dl_d_q[DIV_LAT-1].ray;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        o1_q[i]  <= sat33({ray_i.org[i][31], ray_i.org[i]} - {ctr_i[i][31], ctr_i[i]});
        dd2_q[i] <= $signed(ray1_q.dir[i]) * $signed(ray1_q.dir[i]);
        od2_q[i] <= $signed(o1_q[i]) * $signed(ray1_q.dir[i]);
        oo2_q[i] <= $signed(o1_q[i]) * $signed(o1_q[i]);
      end
      rr2_q   <= radius_i * radius_i;
      c3_q    <= c_sum;
      disc6_q <= disc_d;
      m0_q    <= n0[52] ? 51'(-n0) : n0[50:0];
      m1_q    <= n1[52] ? 51'(-n1) : n1[50:0];
      neg0_q  <= n0[52];
      neg1_q  <= n1[52];
      hit_q   <= dl_d_q[DIV_LAT-1].ray.v & (ok0 | ok1);
      t_q     <= ok0 ? r0 : r1;
    end
  end

  always_comb begin
    hb_mag = coef3_q.hb[50] ? 50'(-coef3_q.hb) : coef3_q.hb[49:0];
    c_mag  = c3_q[50] ? 50'(-c3_q) : c3_q[49:0];
  end

  rsi_mul u_mul_hb (.clk_i, .en_i, .a_i(hb_mag), .b_i(hb_mag), .p_o(hb2));
  rsi_mul u_mul_ac (.clk_i, .en_i, .a_i(coef3_q.a), .b_i(c_mag), .p_o(ac));

  always_comb begin
    if (coef5_q.cle) begin
      disc_d = hb2 + ac;
      pos_d  = disc_d != '0;
    end else begin
      pos_d  = hb2 > ac;
      disc_d = hb2 - ac;
    end
    pos_d = pos_d & coef5_q.anz;
  end

  rsi_sqrt u_sqrt (.clk_i, .en_i, .rad_i(disc6_q), .root_o(s));

  always_comb begin
    n0 = -{{2{dl_s_q[SQRT_LAT-1].hb[50]}}, dl_s_q[SQRT_LAT-1].hb} - {3'd0, s};
    n1 = -{{2{dl_s_q[SQRT_LAT-1].hb[50]}}, dl_s_q[SQRT_LAT-1].hb} + {3'd0, s};
  end

  rsi_div u_div0 (.clk_i, .en_i, .m_i(m0_q), .den_i(qn_q.a[48:0]), .ovf_o(ovf0), .q_o(q0));
  rsi_div u_div1 (.clk_i, .en_i, .m_i(m1_q), .den_i(qn_q.a[48:0]), .ovf_o(ovf1), .q_o(q1));

  logic neg0_d [DIV_LAT];
  logic neg1_d [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg0_d[0] <= neg0_q;
      neg1_d[0] <= neg1_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        neg0_d[k] <= neg0_d[k-1];
        neg1_d[k] <= neg1_d[k-1];
      end
    end
  end

  always_comb begin
    logic [31:0] best;
    best = dl_d_q[DIV_LAT-1].ray.best;
    r0  = sat_root(neg0_d[DIV_LAT-1], ovf0, q0);
    r1  = sat_root(neg1_d[DIV_LAT-1], ovf1, q1);
    ok0 = dl_d_q[DIV_LAT-1].pos && ($signed(r0) > $signed(min_dist_i))
          && (best[31] || ($signed(best) > $signed(r0)));
    ok1 = dl_d_q[DIV_LAT-1].pos && ($signed(r1) > $signed(min_dist_i))
          && (best[31] || ($signed(best) > $signed(r1)));
  end

  assign ray_o = ray_q;
  assign hit_o = hit_q;
  assign t_o   = t_q;

endmodule

/* sv/rsi_shade.sv */
// Hit shading: hit point, unit outward normal and ray-facing normal.
// Depends on rsi_pkg, rsi_sqrt and rsi_div.
module rsi_shade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rsi_pkg::rsi_ray_t  ray_i,
  input  logic               hit_i,
  input  logic [31:0]        t_i,
  input  logic [2:0][31:0]   ctr_i,
  output logic               v_o,
  output rsi_pkg::rsi_res_t  res_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic             v;
    logic             hit;
    logic             lz;
    logic [31:0]      t;
    logic [31:0]      best;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] pt;
    logic [2:0][32:0] diff;
  } shd_t;

  shd_t              sb1_q, sb2_q, sb3_q, sb4_q, sb5_q, sbn_q, sbd_q;
  shd_t              sb2_d, sb3_d;
  shd_t              dl_s_q [SQRT_LAT];
  shd_t              dl_d_q [DIV_LAT];
  shd_t              sqrt_out;
  logic [2:0][63:0]  prod1_q;
  logic [2:0][65:0]  sq4_q;
  logic [2:0][32:0]  dmag;
  logic [67:0]       len2_q;
  logic [49:0]       len;
  logic [2:0][32:0]  q;
  logic [2:0]        ovf;
  logic [2:0][NORM_W-1:0] nrm_d, nrmn_q, nrmd_q;
  logic [2:0][49:0]  dp_q;
  logic [51:0]       dot;
  logic              v_q;
  rsi_res_t          res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = sb3_q.diff[i][32] ? 33'(-sb3_q.diff[i]) : sb3_q.diff[i];
    end
    sqrt_out    = dl_s_q[SQRT_LAT-1];
    sqrt_out.lz = len == '0;
  end

  always_comb begin
    sb2_d = sb1_q;
    sb3_d = sb2_q;
    for (int i = 0; i < 3; i++) begin
      sb2_d.pt[i] = sb1_q.hit ?
        sat49({{17{sb1_q.org[i][31]}}, sb1_q.org[i]} + {prod1_q[i][63], prod1_q[i][63:16]})
        : '0;
      sb3_d.diff[i] = {sb2_q.pt[i][31], sb2_q.pt[i]} - {ctr_i[i][31], ctr_i[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q.v <= 1'b0;
      sb2_q.v <= 1'b0;
      sb3_q.v <= 1'b0;
      sb4_q.v <= 1'b0;
      sb5_q.v <= 1'b0;
      sbn_q.v <= 1'b0;
      sbd_q.v <= 1'b0;
      v_q     <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) dl_s_q[k].v <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dl_d_q[k].v <= 1'b0;
    end else if (en_i) begin
      sb1_q <= '{v: ray_i.v, hit: hit_i, lz: 1'b0, t: t_i, best: ray_i.best,
                 org: ray_i.org, dir: ray_i.dir, pt: '0, diff: '0};
      sb2_q <= sb2_d;
      sb3_q <= sb3_d;
      sb4_q <= sb3_q;
      sb5_q <= sb4_q;
      dl_s_q[0] <= sb5_q;
      for (int k = 1; k < SQRT_LAT; k++) dl_s_q[k] <= dl_s_q[k-1];
      dl_d_q[0] <= sqrt_out;
      for (int k = 1; k < DIV_LAT; k++) dl_d_q[k] <= dl_d_q[k-1];
      sbn_q <= dl_d_q[DIV_LAT-1];
      sbd_q <= sbn_q;
      v_q   <= sbd_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= $signed(ray_i.dir[i]) * $signed(t_i);
        sq4_q[i]   <= dmag[i] * dmag[i];
      end
      len2_q <= {2'd0, sq4_q[0]} + {2'd0, sq4_q[1]} + {2'd0, sq4_q[2]};
      nrmn_q <= nrm_d;
      nrmd_q <= nrmn_q;
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= $signed(sbn_q.dir[i]) * $signed(nrmn_q[i]);
      end
      res_q.hit   <= sbd_q.hit;
      res_q.hit_t <= sbd_q.hit ? sbd_q.t : sbd_q.best;
      res_q.point <= sbd_q.pt;
      res_q.normal <= nrmd_q;
      for (int i = 0; i < 3; i++) begin
        res_q.facing[i] <= dot[51] ? nrmd_q[i] : NORM_W'(-nrmd_q[i]);
      end
    end
  end

  rsi_sqrt u_sqrt (.clk_i, .en_i, .rad_i({32'd0, len2_q}), .root_o(len));

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rsi_div u_div (
      .clk_i, .en_i,
      .m_i   ({18'd0, 33'(dl_s_q[SQRT_LAT-1].diff[i][32] ?
                  -dl_s_q[SQRT_LAT-1].diff[i] : dl_s_q[SQRT_LAT-1].diff[i])}),
      .den_i (len[48:0]),
      .ovf_o (ovf[i]),
      .q_o   (q[i])
    );

    always_comb begin
      if (!dl_d_q[DIV_LAT-1].hit || dl_d_q[DIV_LAT-1].lz || ovf[i]) nrm_d[i] = '0;
      else if (dl_d_q[DIV_LAT-1].diff[i][32]) nrm_d[i] = -{1'b0, q[i][16:0]};
      else nrm_d[i] = {1'b0, q[i][16:0]};
    end
  end

  always_comb begin
    dot = {{2{dp_q[0][49]}}, dp_q[0]} + {{2{dp_q[1][49]}}, dp_q[1]}
        + {{2{dp_q[2][49]}}, dp_q[2]};
  end

  assign v_o   = v_q;
  assign res_o = res_q;

endmodule

/* sv/ray_sphere_intersect_unit.sv */
// Top level of the ray/sphere intersection unit: config registers, core pipeline, output skid.
// Depends on rsi_pkg, rsi_if, rsi_root and rsi_shade.
//
//   channel   dir   handshake     payload
//   ray_i     in    valid/ready   ray origin, direction, best_t
//   hit_o     out   valid/ready   hit, hit_t, point, normal, facing
//   cfg       in    cfg_we_i      cfg_idx_i selects register, cfg_data_i
//
// One item per cycle while the skid is not full; latency from ray_i to hit_o is set by the
// two 50-stage square roots and the two banks of 34-stage dividers in series.
// Reset clears all valid bits and loads the config defaults (radius 1.0).
// A stalled result parks in a one-entry skid; the pipeline freezes only while it is full.
module ray_sphere_intersect_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rsi_ray_if.sink     ray_i,
  rsi_hit_if.source   hit_o
);
  import rsi_pkg::*;

  logic [2:0][31:0] ctr_q;
  logic [30:0]      radius_q;
  logic [31:0]      min_q;
  logic             en;
  rsi_ray_t         ray_in;
  rsi_ray_t         ray_r;
  logic             hit_r;
  logic [31:0]      t_r;
  logic             core_v;
  rsi_res_t         core_res;
  logic             out_v_q, skid_v_q;
  rsi_res_t         out_res_q, skid_res_q;
  logic             push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q    <= '0;
      radius_q <= 31'(1 << FRAC_BITS);
      min_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: ctr_q[0] <= cfg_data_i;
        CFG_CENTER_Y: ctr_q[1] <= cfg_data_i;
        CFG_CENTER_Z: ctr_q[2] <= cfg_data_i;
        CFG_RADIUS:   radius_q <= cfg_data_i[30:0];
        CFG_MIN_DIST: min_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en          = !skid_v_q;
  assign ray_i.ready = en;

  always_comb begin
    ray_in.v      = ray_i.valid;
    ray_in.org[0] = ray_i.ray_origin_x;
    ray_in.org[1] = ray_i.ray_origin_y;
    ray_in.org[2] = ray_i.ray_origin_z;
    ray_in.dir[0] = ray_i.ray_dir_x;
    ray_in.dir[1] = ray_i.ray_dir_y;
    ray_in.dir[2] = ray_i.ray_dir_z;
    ray_in.best   = ray_i.best_t;
  end

  rsi_root u_root (
    .clk_i, .rst_ni, .en_i(en), .ray_i(ray_in), .ctr_i(ctr_q), .radius_i(radius_q),
    .min_dist_i(min_q), .ray_o(ray_r), .hit_o(hit_r), .t_o(t_r)
  );

  rsi_shade u_shade (
    .clk_i, .rst_ni, .en_i(en), .ray_i(ray_r), .hit_i(hit_r), .t_i(t_r), .ctr_i(ctr_q),
    .v_o(core_v), .res_o(core_res)
  );

  assign push = en && core_v;
  assign pop  = out_v_q && hit_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_res_q <= skid_res_q;
    end else if (push) begin
      if (out_v_q && !pop) skid_res_q <= core_res;
      else out_res_q <= core_res;
    end
  end

  assign hit_o.valid    = out_v_q;
  assign hit_o.hit      = out_res_q.hit;
  assign hit_o.hit_t    = out_res_q.hit_t;
  assign hit_o.point_x  = out_res_q.point[0];
  assign hit_o.point_y  = out_res_q.point[1];
  assign hit_o.point_z  = out_res_q.point[2];
  assign hit_o.normal_x = out_res_q.normal[0];
  assign hit_o.normal_y = out_res_q.normal[1];
  assign hit_o.normal_z = out_res_q.normal[2];
  assign hit_o.facing_x = out_res_q.facing[0];
  assign hit_o.facing_y = out_res_q.facing[1];
  assign hit_o.facing_z = out_res_q.facing[2];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds an item while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_v_q && !hit_o.ready) |=> skid_v_q)
    else $error("stalled item was not parked in skid");

  a_hit_beyond_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_res_q.hit) |-> ($signed(out_res_q.hit_t) > $signed(min_q)))
    else $error("hit distance not beyond minimum distance");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_res_q.hit) |-> (out_res_q.point == '0 && out_res_q.normal == '0
                                     && out_res_q.facing == '0))
    else $error("miss carries nonzero geometry");

endmodule
